// ===== hw/rtl/mcsc_pkg.sv =====
// ----------------------------------------------------------------------------
// mcsc_pkg
// Shared types, codes and constants of the pointer event classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package mcsc_pkg;

  localparam int TimeBitsDef  = 32;
  localparam int CoordBitsDef = 16;

  // configuration reset values (ms)
  localparam logic [15:0] ClickWindowRst  = 16'd400;
  localparam logic [15:0] RepeatDelayRst  = 16'd400;
  localparam logic [15:0] RepeatPeriodRst = 16'd100;
  localparam logic [15:0] RepeatWaitRst   = 16'd500;

  // configuration register indexes
  localparam logic [1:0] CfgClickWindow  = 2'd0;
  localparam logic [1:0] CfgRepeatDelay  = 2'd1;
  localparam logic [1:0] CfgRepeatPeriod = 2'd2;

  // request types
  localparam logic [2:0] ReqTick   = 3'd0;
  localparam logic [2:0] ReqOther  = 3'd1;
  localparam logic [2:0] ReqButton = 3'd2;
  localparam logic [2:0] ReqMove   = 3'd3;
  localparam logic [2:0] ReqShift  = 3'd4;

  // button actions
  localparam logic [2:0] ActMidDown   = 3'd2;
  localparam logic [2:0] ActWheelDown = 3'd4;
  localparam logic [2:0] ActLeftUp    = 3'd5;

  // event classes
  localparam logic [3:0] EvNone    = 4'd0;
  localparam logic [3:0] EvClick   = 4'd1;
  localparam logic [3:0] EvRelease = 4'd2;
  localparam logic [3:0] EvDrag    = 4'd3;
  localparam logic [3:0] EvMove    = 4'd4;
  localparam logic [3:0] EvRepeat  = 4'd5;
  localparam logic [3:0] EvDouble  = 4'd6;
  localparam logic [3:0] EvTriple  = 4'd7;
  localparam logic [3:0] EvOther   = 4'd8;

  localparam logic [4:0] CodeLeft = 5'd1;
  localparam logic [2:0] MaskLeft = 3'b001;

  // result queue
  localparam int RqDepth = 4;
  localparam int RqPtrW  = $clog2(RqDepth);
  localparam int RqCntW  = $clog2(RqDepth + 1);

  typedef enum logic [2:0] {
    SEQ_NONE    = 3'b001,
    SEQ_CLICK   = 3'b010,
    SEQ_RELEASE = 3'b100
  } seq_state_t;

  typedef struct packed {
    logic [15:0] click_window;
    logic [15:0] repeat_delay;
    logic [15:0] repeat_period;
  } cfg_t;

  typedef struct packed {
    logic [3:0]         event_class;
    logic [4:0]         event_code;
    logic [2:0]         btn_state;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic               last;
  } result_t;

  typedef struct packed {
    logic    one;
    logic    two;
    result_t res0;
    result_t res1;
  } push_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mcsc_in_if.sv =====
// ----------------------------------------------------------------------------
// mcsc_in_if
// Request channel: one timestamped pointer request per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcsc_in_if #(
  parameter int TB = mcsc_pkg::TimeBitsDef
);
  logic                valid;
  logic                ready;
  logic [2:0]          req_type;
  logic [2:0]          button_action;
  logic [2:0]          held_buttons;
  logic signed [15:0]  pos_x;
  logic signed [15:0]  pos_y;
  logic [TB-1:0]       time_ms;

  modport source (
    output valid, req_type, button_action, held_buttons, pos_x, pos_y, time_ms,
    input  ready
  );

  modport sink (
    input  valid, req_type, button_action, held_buttons, pos_x, pos_y, time_ms,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/mcsc_out_if.sv =====
// ----------------------------------------------------------------------------
// mcsc_out_if
// Result channel: one classified pointer event per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcsc_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         event_class;
  logic [4:0]         event_code;
  logic [2:0]         btn_state;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] origin_x;
  logic signed [15:0] origin_y;
  logic               last;

  modport source (
    output valid, event_class, event_code, btn_state, out_x, out_y,
           origin_x, origin_y, last,
    input  ready
  );

  modport sink (
    input  valid, event_class, event_code, btn_state, out_x, out_y,
           origin_x, origin_y, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/mcsc_core.sv =====
// ----------------------------------------------------------------------------
// mcsc_core
// Request register plus single-pass classification, click-run tracking and
// left-button auto-repeat. Pushes zero, one or two results per request.
// ----------------------------------------------------------------------------
`default_nettype none

module mcsc_core #(
  parameter int TIME_BITS  = mcsc_pkg::TimeBitsDef,
  parameter int COORD_BITS = mcsc_pkg::CoordBitsDef
) (
  input  wire                 clk,
  input  wire                 rst_n,
  mcsc_in_if.sink             in_req,
  input  mcsc_pkg::cfg_t      cfg,
  input  wire                 q_room,
  output mcsc_pkg::push_t     push
);

  // request stage
  logic                  stg_vld_r, stg_vld_nxt;
  logic [2:0]            typ_r, act_r, held_r;
  logic signed [15:0]    px_r, py_r;
  logic [TIME_BITS-1:0]  t_r;

  // tracking state
  mcsc_pkg::seq_state_t  seq_r, seq_nxt;
  logic [4:0]            seq_btn_r, seq_btn_nxt;
  logic [TIME_BITS-1:0]  seq_time_r, seq_time_nxt;
  logic [1:0]            run_r, run_nxt;
  logic [2:0]            pm_r, pm_nxt;
  logic [TIME_BITS-1:0]  press_time_r, press_time_nxt;
  logic [15:0]           wait_r, wait_nxt;
  logic [COORD_BITS-1:0] org_x_r, org_x_nxt, org_y_r, org_y_nxt;

  logic                  in_acc, adv;
  logic [TIME_BITS-1:0]  d_seq, d_press;
  logic                  in_win, rpt_due;
  logic [3:0]            cls, rcls, meta;
  logic [4:0]            code, rcode;
  logic [1:0]            run_inc;

  assign in_req.ready = !stg_vld_r || q_room;
  assign in_acc       = in_req.valid && in_req.ready;
  assign adv          = stg_vld_r && q_room;

  assign d_seq   = t_r - seq_time_r;
  assign d_press = t_r - press_time_r;
  assign in_win  = d_seq <= TIME_BITS'(cfg.click_window);
  assign rpt_due = d_press > TIME_BITS'(wait_r);
  assign run_inc = run_r + 2'd1;

  always_comb begin
    stg_vld_nxt    = in_acc ? 1'b1 : (adv ? 1'b0 : stg_vld_r);
    seq_nxt        = seq_r;
    seq_btn_nxt    = seq_btn_r;
    seq_time_nxt   = seq_time_r;
    run_nxt        = run_r;
    pm_nxt         = pm_r;
    press_time_nxt = press_time_r;
    wait_nxt       = wait_r;
    org_x_nxt      = org_x_r;
    org_y_nxt      = org_y_r;
    cls            = mcsc_pkg::EvNone;
    code           = 5'd0;
    meta           = mcsc_pkg::EvNone;
    rcls           = mcsc_pkg::EvNone;
    rcode          = 5'd0;

    // classification
    case (typ_r)
      mcsc_pkg::ReqOther: begin
        cls = mcsc_pkg::EvOther;
      end
      mcsc_pkg::ReqButton: begin
        pm_nxt = held_r;
        if (act_r <= mcsc_pkg::ActWheelDown) begin
          cls  = mcsc_pkg::EvClick;
          code = 5'd1 << act_r;
          if (act_r <= mcsc_pkg::ActMidDown) begin
            pm_nxt = held_r | code[2:0];
          end
          org_x_nxt = COORD_BITS'(px_r);
          org_y_nxt = COORD_BITS'(py_r);
        end else begin
          cls    = mcsc_pkg::EvRelease;
          code   = 5'd1 << (act_r - mcsc_pkg::ActLeftUp);
          pm_nxt = held_r & ~code[2:0];
        end
      end
      mcsc_pkg::ReqMove: begin
        if (held_r != 3'd0) begin
          cls  = mcsc_pkg::EvDrag;
          code = {2'b00, held_r};
        end else begin
          cls = mcsc_pkg::EvMove;
        end
      end
      mcsc_pkg::ReqShift: begin
        org_x_nxt = org_x_r + COORD_BITS'(px_r);
        org_y_nxt = org_y_r + COORD_BITS'(py_r);
      end
      default: begin
        cls = mcsc_pkg::EvNone;
      end
    endcase

    // click/release runs
    if (cls == mcsc_pkg::EvClick) begin
      if (!(seq_r == mcsc_pkg::SEQ_RELEASE && seq_btn_r == code && in_win)) begin
        seq_btn_nxt = code;
        run_nxt     = 2'd0;
      end
      seq_nxt      = mcsc_pkg::SEQ_CLICK;
      seq_time_nxt = t_r;
    end else if (cls == mcsc_pkg::EvRelease && seq_r == mcsc_pkg::SEQ_CLICK &&
                 seq_btn_r == code && in_win) begin
      seq_nxt      = mcsc_pkg::SEQ_RELEASE;
      seq_time_nxt = t_r;
      run_nxt      = run_inc;
      if (run_inc == 2'd2) begin
        meta = mcsc_pkg::EvDouble;
      end else if (run_inc == 2'd3) begin
        meta    = mcsc_pkg::EvTriple;
        run_nxt = 2'd0;
      end
    end else if (cls != mcsc_pkg::EvNone && seq_r != mcsc_pkg::SEQ_NONE) begin
      seq_nxt      = mcsc_pkg::SEQ_NONE;
      seq_btn_nxt  = 5'd0;
      seq_time_nxt = '0;
      run_nxt      = 2'd0;
    end

    // left-button auto-repeat
    rcls  = cls;
    rcode = code;
    if (cls == mcsc_pkg::EvClick && code == mcsc_pkg::CodeLeft) begin
      press_time_nxt = t_r;
      wait_nxt       = cfg.repeat_delay;
    end else if (pm_nxt == 3'd0) begin
      press_time_nxt = '0;
    end else if (pm_nxt == mcsc_pkg::MaskLeft && rpt_due) begin
      wait_nxt       = cfg.repeat_period;
      press_time_nxt = t_r;
      rcls           = mcsc_pkg::EvRepeat;
      rcode          = {2'b00, pm_nxt};
    end

    // shift requests only move the origin
    if (typ_r == mcsc_pkg::ReqShift) begin
      seq_nxt        = seq_r;
      seq_btn_nxt    = seq_btn_r;
      seq_time_nxt   = seq_time_r;
      run_nxt        = run_r;
      pm_nxt         = pm_r;
      press_time_nxt = press_time_r;
      wait_nxt       = wait_r;
    end
  end

  always_comb begin
    push.one               = adv && (typ_r != mcsc_pkg::ReqShift);
    push.two               = push.one && (meta != mcsc_pkg::EvNone);
    push.res0.event_class  = rcls;
    push.res0.event_code   = rcode;
    push.res0.btn_state    = pm_nxt;
    push.res0.out_x        = px_r;
    push.res0.out_y        = py_r;
    push.res0.origin_x     = 16'(org_x_nxt);
    push.res0.origin_y     = 16'(org_y_nxt);
    push.res0.last         = (meta == mcsc_pkg::EvNone);
    push.res1              = push.res0;
    push.res1.event_class  = meta;
    push.res1.event_code   = code;
    push.res1.last         = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r    <= 1'b0;
      seq_r        <= mcsc_pkg::SEQ_NONE;
      seq_btn_r    <= 5'd0;
      seq_time_r   <= '0;
      run_r        <= 2'd0;
      pm_r         <= 3'd0;
      press_time_r <= '0;
      wait_r       <= mcsc_pkg::RepeatWaitRst;
      org_x_r      <= '1;
      org_y_r      <= '1;
    end else begin
      stg_vld_r <= stg_vld_nxt;
      if (adv) begin
        seq_r        <= seq_nxt;
        seq_btn_r    <= seq_btn_nxt;
        seq_time_r   <= seq_time_nxt;
        run_r        <= run_nxt;
        pm_r         <= pm_nxt;
        press_time_r <= press_time_nxt;
        wait_r       <= wait_nxt;
        org_x_r      <= org_x_nxt;
        org_y_r      <= org_y_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      typ_r  <= in_req.req_type;
      act_r  <= in_req.button_action;
      held_r <= in_req.held_buttons;
      px_r   <= in_req.pos_x;
      py_r   <= in_req.pos_y;
      t_r    <= TIME_BITS'(in_req.time_ms);
    end
  end

`ifndef NO_ASSERTIONS
  a_meta_class: assert property (@(posedge clk) disable iff (!rst_n)
    push.two |-> (push.res1.event_class == mcsc_pkg::EvDouble ||
                  push.res1.event_class == mcsc_pkg::EvTriple))
    else $error("second result is not a double or triple click");

  a_meta_last: assert property (@(posedge clk) disable iff (!rst_n)
    push.two |-> (push.one && !push.res0.last))
    else $error("first of two results marked last");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_vld_r && !q_room) |=> (stg_vld_r && $stable(t_r) && $stable(typ_r)))
    else $error("blocked request lost from stage");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/mcsc_rq.sv =====
// ----------------------------------------------------------------------------
// mcsc_rq
// Small result queue; takes one or two results per push, drains one per
// handshake on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mcsc_rq (
  input  wire                 clk,
  input  wire                 rst_n,
  input  mcsc_pkg::push_t     push,
  output logic                q_room,
  output logic                head_vld,
  output mcsc_pkg::result_t   head,
  input  wire                 head_rdy
);

  mcsc_pkg::result_t                q_r [mcsc_pkg::RqDepth];
  logic [mcsc_pkg::RqPtrW-1:0]      wr_r, wr_nxt, rd_r, rd_nxt, wr1;
  logic [mcsc_pkg::RqCntW-1:0]      cnt_r, cnt_nxt;
  logic                             pop;

  assign head_vld = cnt_r != '0;
  assign head     = q_r[rd_r];
  assign pop      = head_vld && head_rdy;
  assign q_room   = cnt_r <= mcsc_pkg::RqCntW'(mcsc_pkg::RqDepth - 2);
  assign wr1      = wr_r + mcsc_pkg::RqPtrW'(1);

  always_comb begin
    wr_nxt  = wr_r + mcsc_pkg::RqPtrW'(push.one) + mcsc_pkg::RqPtrW'(push.two);
    rd_nxt  = rd_r + mcsc_pkg::RqPtrW'(pop);
    cnt_nxt = cnt_r + mcsc_pkg::RqCntW'(push.one) + mcsc_pkg::RqCntW'(push.two)
              - mcsc_pkg::RqCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.one) begin
      q_r[wr_r] <= push.res0;
    end
    if (push.two) begin
      q_r[wr1] <= push.res1;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= mcsc_pkg::RqCntW'(mcsc_pkg::RqDepth))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.one |-> q_room)
    else $error("push without room");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push.one) |=> cnt_r == $past(cnt_r) - mcsc_pkg::RqCntW'(1))
    else $error("count not decremented on pop");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/mouse_click_sequence_classifier_top.sv =====
// ----------------------------------------------------------------------------
// mouse_click_sequence_classifier_top
// Pointer event classifier with double/triple-click detection and
// left-button auto-repeat.
//
// Usage:
//   in_req  : one timestamped pointer request per valid/ready handshake.
//   out_res : classified events; a request gives one result, a release that
//             closes a double or triple click gives two (last marks the
//             final one), an origin shift gives none.
//   cfg_*   : write-only registers (click window, repeat delay, repeat
//             period); write only while the block is idle.
// Flow: an accepted request is registered and classified in the request
//   stage; its results go into the result queue, whose head drives out_res.
// Throughput: one request per cycle while the queue has room for two
//   results. The four-entry result queue sets the slack.
// Reset: registers return to their defaults, tracking state clears, the
//   click origin becomes -1/-1 and the queue empties.
// Stall: while out_res.ready is low the queue fills; in_req.ready drops
//   once the stage is full and fewer than two queue entries are free.
// ----------------------------------------------------------------------------
`default_nettype none

module mouse_click_sequence_classifier_top #(
  parameter int TIME_BITS  = mcsc_pkg::TimeBitsDef,
  parameter int COORD_BITS = mcsc_pkg::CoordBitsDef
) (
  input  wire         clk,
  input  wire         rst_n,
  mcsc_in_if.sink     in_req,
  mcsc_out_if.source  out_res,
  input  wire         cfg_we,
  input  wire [1:0]   cfg_idx,
  input  wire [15:0]  cfg_data
);

  mcsc_pkg::cfg_t    cfg_r;
  mcsc_pkg::push_t   push;
  mcsc_pkg::result_t head;
  logic              q_room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.click_window  <= mcsc_pkg::ClickWindowRst;
      cfg_r.repeat_delay  <= mcsc_pkg::RepeatDelayRst;
      cfg_r.repeat_period <= mcsc_pkg::RepeatPeriodRst;
    end else if (cfg_we) begin
      case (cfg_idx)
        mcsc_pkg::CfgClickWindow:  cfg_r.click_window  <= cfg_data;
        mcsc_pkg::CfgRepeatDelay:  cfg_r.repeat_delay  <= cfg_data;
        mcsc_pkg::CfgRepeatPeriod: cfg_r.repeat_period <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mcsc_core #(
    .TIME_BITS  (TIME_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .cfg    (cfg_r),
    .q_room (q_room),
    .push   (push)
  );

  mcsc_rq u_rq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .q_room   (q_room),
    .head_vld (out_res.valid),
    .head     (head),
    .head_rdy (out_res.ready)
  );

  assign out_res.event_class  = head.event_class;
  assign out_res.event_code   = head.event_code;
  assign out_res.btn_state    = head.btn_state;
  assign out_res.out_x        = head.out_x;
  assign out_res.out_y        = head.out_y;
  assign out_res.origin_x     = head.origin_x;
  assign out_res.origin_y     = head.origin_y;
  assign out_res.last         = head.last;

endmodule

`default_nettype wire

// ===== test/mcsc_event_checker.sv =====
// ----------------------------------------------------------------------------
// mcsc_event_checker
// Watches the request, result and register ports of the pointer event
// classifier. It keeps its own copy of the tracking state and of the
// registers, works out the events due for every accepted request, and
// compares each result, field by field, with the oldest event still due.
// ----------------------------------------------------------------------------
`default_nettype none

module mcsc_event_checker (
  input  wire         clk,
  input  wire         rst_n,
  mcsc_in_if          in_req,
  mcsc_out_if         out_res,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_idx,
  input  wire  [15:0] cfg_data,
  output int unsigned mismatches,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0]          win_ms;
  logic [15:0]          delay_ms;
  logic [15:0]          period_ms;

  mcsc_pkg::seq_state_t seq;
  logic [4:0]           seq_btn;
  logic [31:0]          seq_stamp;
  logic [1:0]           run_len;
  logic [2:0]           btn_mask;
  logic [31:0]          press_stamp;
  logic [15:0]          rpt_wait;
  logic signed [15:0]   org_x;
  logic signed [15:0]   org_y;

  mcsc_pkg::result_t    due_events[$];
  mcsc_pkg::result_t    want;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
    mismatches++;
    $display("%0t: event check: %s got %0h, want %0h", $time, what, got, exp_v);
  endtask

  function automatic mcsc_pkg::result_t make_event(input logic [3:0] cls,
                                                   input logic [4:0] code,
                                                   input logic signed [15:0] x, y,
                                                   input logic fin);
    mcsc_pkg::result_t r;
    r.event_class  = cls;
    r.event_code   = code;
    r.btn_state    = btn_mask;
    r.out_x        = x;
    r.out_y        = y;
    r.origin_x     = org_x;
    r.origin_y     = org_y;
    r.last         = fin;
    return r;
  endfunction

  function automatic void reset_tracking();
    win_ms      = mcsc_pkg::ClickWindowRst;
    delay_ms    = mcsc_pkg::RepeatDelayRst;
    period_ms   = mcsc_pkg::RepeatPeriodRst;
    seq         = mcsc_pkg::SEQ_NONE;
    seq_btn     = '0;
    seq_stamp   = '0;
    run_len     = '0;
    btn_mask    = '0;
    press_stamp = '0;
    rpt_wait    = mcsc_pkg::RepeatWaitRst;
    org_x       = -16'sd1;
    org_y       = -16'sd1;
    due_events.delete();
  endfunction

  function automatic void classify_request(input logic [2:0] typ, act, held,
                                           input logic signed [15:0] x, y,
                                           input logic [31:0] t);
    logic [3:0]  cls;
    logic [3:0]  meta;
    logic [4:0]  code;
    logic [4:0]  btn_code;
    logic [31:0] since_seq;
    logic [31:0] since_press;
    cls  = mcsc_pkg::EvNone;
    meta = mcsc_pkg::EvNone;
    code = '0;
    if (typ == mcsc_pkg::ReqShift) begin
      org_x = org_x + x;
      org_y = org_y + y;
      return;
    end
    case (typ)
      mcsc_pkg::ReqOther: cls = mcsc_pkg::EvOther;
      mcsc_pkg::ReqButton: begin
        btn_mask = held;
        if (act <= mcsc_pkg::ActWheelDown) begin
          cls  = mcsc_pkg::EvClick;
          code = 5'd1 << act;
          if (act <= mcsc_pkg::ActMidDown) btn_mask = btn_mask | code[2:0];
          org_x = x;
          org_y = y;
        end else begin
          cls      = mcsc_pkg::EvRelease;
          code     = 5'd1 << (act - mcsc_pkg::ActLeftUp);
          btn_mask = btn_mask & ~code[2:0];
        end
      end
      mcsc_pkg::ReqMove: begin
        if (held != '0) begin
          cls  = mcsc_pkg::EvDrag;
          code = {2'b00, held};
        end else begin
          cls = mcsc_pkg::EvMove;
        end
      end
      default: ;
    endcase

    // click/release runs
    since_seq = t - seq_stamp;
    if (cls == mcsc_pkg::EvClick) begin
      if (!(seq == mcsc_pkg::SEQ_RELEASE && seq_btn == code &&
            since_seq <= {16'd0, win_ms})) begin
        seq_btn = code;
        run_len = '0;
      end
      seq       = mcsc_pkg::SEQ_CLICK;
      seq_stamp = t;
    end else if (cls == mcsc_pkg::EvRelease && seq == mcsc_pkg::SEQ_CLICK &&
                 seq_btn == code && since_seq <= {16'd0, win_ms}) begin
      seq       = mcsc_pkg::SEQ_RELEASE;
      seq_stamp = t;
      run_len   = run_len + 2'd1;
      if (run_len == 2'd2) begin
        meta = mcsc_pkg::EvDouble;
      end else if (run_len == 2'd3) begin
        meta    = mcsc_pkg::EvTriple;
        run_len = '0;
      end
    end else if (cls != mcsc_pkg::EvNone && seq != mcsc_pkg::SEQ_NONE) begin
      seq       = mcsc_pkg::SEQ_NONE;
      seq_btn   = '0;
      seq_stamp = '0;
      run_len   = '0;
    end

    // left button auto-repeat
    btn_code    = code;
    since_press = t - press_stamp;
    if (cls == mcsc_pkg::EvClick && code == mcsc_pkg::CodeLeft) begin
      press_stamp = t;
      rpt_wait    = delay_ms;
    end else if (btn_mask == '0) begin
      press_stamp = '0;
    end else if (btn_mask == mcsc_pkg::MaskLeft && since_press > {16'd0, rpt_wait}) begin
      rpt_wait    = period_ms;
      press_stamp = t;
      cls         = mcsc_pkg::EvRepeat;
      code        = {2'b00, btn_mask};
    end

    due_events.push_back(make_event(cls, code, x, y, meta == mcsc_pkg::EvNone));
    if (meta != mcsc_pkg::EvNone) due_events.push_back(make_event(meta, btn_code, x, y, 1'b1));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mismatches = 0;
      reset_tracking();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          mcsc_pkg::CfgClickWindow:  win_ms    = cfg_data;
          mcsc_pkg::CfgRepeatDelay:  delay_ms  = cfg_data;
          mcsc_pkg::CfgRepeatPeriod: period_ms = cfg_data;
          default: ;
        endcase
      end
      if (in_req.valid && in_req.ready) begin
        classify_request(in_req.req_type, in_req.button_action, in_req.held_buttons,
                         in_req.pos_x, in_req.pos_y, in_req.time_ms);
      end
      if (out_res.valid && out_res.ready) begin
        if (due_events.size() == 0) begin
          report("event with none due, class", 32'(out_res.event_class),
                 32'(mcsc_pkg::EvNone));
        end else begin
          want = due_events.pop_front();
          if (out_res.event_class !== want.event_class)
            report("event_class", 32'(out_res.event_class), 32'(want.event_class));
          if (out_res.event_code !== want.event_code)
            report("event_code", 32'(out_res.event_code), 32'(want.event_code));
          if (out_res.btn_state !== want.btn_state)
            report("btn_state", 32'(out_res.btn_state), 32'(want.btn_state));
          if (out_res.out_x !== want.out_x)
            report("out_x", 32'(out_res.out_x), 32'(want.out_x));
          if (out_res.out_y !== want.out_y)
            report("out_y", 32'(out_res.out_y), 32'(want.out_y));
          if (out_res.origin_x !== want.origin_x)
            report("origin_x", 32'(out_res.origin_x), 32'(want.origin_x));
          if (out_res.origin_y !== want.origin_y)
            report("origin_y", 32'(out_res.origin_y), 32'(want.origin_y));
          if (out_res.last !== want.last)
            report("last", 32'(out_res.last), 32'(want.last));
        end
      end
    end
    pending <= due_events.size();
  end

endmodule

`default_nettype wire

// ===== test/mouse_click_sequence_classifier_top_test.sv =====
// ----------------------------------------------------------------------------
// mouse_click_sequence_classifier_top_test
// Drives timestamped pointer requests into the classifier: a directed
// opening, then click runs, held-left auto-repeat sequences, moves, origin
// shifts and random requests under several register settings, with random
// idling on both channels, one long result stall and several full drains.
// The event checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
`default_nettype none

module mouse_click_sequence_classifier_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ActLeftDown  = 3'd0;
  localparam logic [2:0] ActRightDown = 3'd1;
  localparam logic [2:0] ActWheelUp   = 3'd3;
  localparam logic [2:0] ActRightUp   = 3'd6;
  localparam logic [2:0] ActMidUp     = 3'd7;
  localparam logic [2:0] ReqLast      = 3'd7;
  localparam logic [1:0] CfgUnused    = 2'd3;
  localparam int         HoldCycles   = 150;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_data;

  mcsc_in_if  in_req ();
  mcsc_out_if out_res ();

  int unsigned mismatches;
  int unsigned pending;

  logic [15:0] win_ms;
  logic [15:0] delay_ms;
  logic [15:0] period_ms;
  logic [31:0] stamp_ms;
  int unsigned n_sent;
  bit          steady;
  bit          hold_out;
  int unsigned hold_cnt;

  always #5 clk = ~clk;

  mouse_click_sequence_classifier_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .out_res  (out_res),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  mcsc_event_checker watch (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .out_res    (out_res),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    #2_000_000;
    $display("mouse_click_sequence_classifier_top: mismatch");
    $finish;
  end

  // result side: random back-pressure, or a long hold-off when asked
  initial begin
    out_res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_res.ready <= 1'b0;
        hold_cnt++;
        if (hold_cnt >= HoldCycles) begin
          hold_out = 1'b0;
          hold_cnt = 0;
        end
      end else begin
        out_res.ready <= steady || ($urandom_range(0, 99) >= 11);
      end
    end
  end

  function automatic logic [31:0] span_near(input logic [15:0] lim);
    case ($urandom_range(0, 7))
      0: return {16'd0, lim};
      1: return {16'd0, lim} + 32'd1;
      2: return (lim == '0) ? 32'd0 : {16'd0, lim} - 32'd1;
      3: return {16'd0, lim} + 32'd1 + $urandom_range(0, 50);
      4: return $urandom_range(0, 3);
      default: return $urandom_range(0, lim);
    endcase
  endfunction

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] low_held();
    return ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd0;
  endfunction

  task automatic issue(input logic [2:0] typ, act, held, input logic signed [15:0] x, y,
                       input logic [31:0] dt);
    stamp_ms = stamp_ms + dt;
    in_req.valid         <= 1'b1;
    in_req.req_type      <= typ;
    in_req.button_action <= act;
    in_req.held_buttons  <= held;
    in_req.pos_x         <= x;
    in_req.pos_y         <= y;
    in_req.time_ms       <= stamp_ms;
    do @(posedge clk); while (in_req.ready !== 1'b1);
    n_sent++;
    if (!steady && $urandom_range(0, 99) < 11) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_req.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // a shift request gives no result but may still be in flight
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [15:0] cw, rd, rp);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= mcsc_pkg::CfgClickWindow;
    cfg_data <= cw;
    @(posedge clk);
    cfg_idx  <= mcsc_pkg::CfgRepeatDelay;
    cfg_data <= rd;
    @(posedge clk);
    cfg_idx  <= mcsc_pkg::CfgRepeatPeriod;
    cfg_data <= rp;
    @(posedge clk);
    if ($urandom_range(0, 1) == 1) begin
      cfg_idx  <= CfgUnused;
      cfg_data <= 16'($urandom);
      @(posedge clk);
    end
    cfg_we    <= 1'b0;
    win_ms    = cw;
    delay_ms  = rd;
    period_ms = rp;
  endtask

  task automatic click_run();
    logic [2:0] b;
    int         n;
    b = 3'($urandom_range(0, 2));
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      issue(mcsc_pkg::ReqButton, b, low_held(), rand_coord(), rand_coord(),
            (i == 0) ? 32'($urandom_range(0, 100000)) : span_near(win_ms));
      if ($urandom_range(0, 5) == 0)
        issue(mcsc_pkg::ReqTick, 3'($urandom), 3'($urandom), rand_coord(), rand_coord(),
              $urandom_range(0, 3));
      issue(mcsc_pkg::ReqButton, b + mcsc_pkg::ActLeftUp, low_held(), rand_coord(),
            rand_coord(), span_near(win_ms));
      if ($urandom_range(0, 15) == 0)
        issue(mcsc_pkg::ReqOther, 3'($urandom), 3'($urandom), rand_coord(), rand_coord(),
              $urandom_range(0, 3));
    end
  endtask

  task automatic hold_left();
    logic [31:0] dt;
    int          k;
    issue(mcsc_pkg::ReqButton, ActLeftDown,
          ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 1)),
          rand_coord(), rand_coord(), $urandom_range(0, 100000));
    k = $urandom_range(2, 8);
    for (int i = 0; i < k; i++) begin
      dt = span_near((i == 0) ? delay_ms : period_ms);
      case ($urandom_range(0, 9))
        0: issue(mcsc_pkg::ReqMove, 3'($urandom), mcsc_pkg::MaskLeft, rand_coord(),
                 rand_coord(), dt);
        1: issue(mcsc_pkg::ReqOther, 3'($urandom), 3'($urandom), rand_coord(),
                 rand_coord(), dt);
        2: issue(mcsc_pkg::ReqButton, 3'($urandom_range(ActWheelUp, mcsc_pkg::ActWheelDown)),
                 mcsc_pkg::MaskLeft, rand_coord(), rand_coord(), dt);
        3: issue(3'($urandom_range(mcsc_pkg::ReqShift + 1, ReqLast)), 3'($urandom),
                 3'($urandom), rand_coord(), rand_coord(), dt);
        default: issue(mcsc_pkg::ReqTick, 3'($urandom), 3'($urandom), rand_coord(),
                       rand_coord(), dt);
      endcase
    end
    issue(mcsc_pkg::ReqButton, mcsc_pkg::ActLeftUp, 3'($urandom_range(0, 7)), rand_coord(),
          rand_coord(), span_near(period_ms));
  endtask

  task automatic pointer_moves();
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      issue(mcsc_pkg::ReqMove, 3'($urandom),
            ($urandom_range(0, 1) == 1) ? 3'd0 : 3'($urandom_range(1, 7)),
            rand_coord(), rand_coord(), $urandom_range(0, 500));
    end
  endtask

  task automatic random_request();
    issue(3'($urandom), 3'($urandom), 3'($urandom), 16'($urandom), 16'($urandom),
          ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 2000)));
  endtask

  task automatic run_scenes(input int unsigned target);
    int unsigned pick;
    while (n_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) click_run();
      else if (pick < 55) hold_left();
      else if (pick < 67) pointer_moves();
      else if (pick < 72)
        issue(mcsc_pkg::ReqShift, 3'($urandom), 3'($urandom), rand_coord(), rand_coord(),
              $urandom_range(0, 50));
      else if (pick < 75)
        issue(mcsc_pkg::ReqOther, 3'($urandom), 3'($urandom), rand_coord(), rand_coord(),
              $urandom_range(0, 50));
      else random_request();
    end
  endtask

  task automatic directed();
    issue(mcsc_pkg::ReqOther, ReqLast, ReqLast, 16'sh8000, 16'sh7fff, 0);
    issue(mcsc_pkg::ReqMove, ActLeftDown, 3'd0, 16'sh0000, 16'sh0000, 1);
    issue(mcsc_pkg::ReqMove, ActLeftDown, 3'd7, -16'sd1, 16'sd1, 1);
    // wheel click latches the origin, then a wrapping shift
    issue(mcsc_pkg::ReqButton, ActWheelUp, 3'd0, 16'sh7fff, 16'sh8000, 5);
    issue(mcsc_pkg::ReqShift, ActLeftDown, 3'd0, 16'sd1, -16'sd1, 0);
    issue(mcsc_pkg::ReqButton, mcsc_pkg::ActWheelDown, 3'd7, 16'sd3, 16'sd4, 5);
    // right button: single, double, triple
    for (int i = 0; i < 3; i++) begin
      issue(mcsc_pkg::ReqButton, ActRightDown, 3'd0, 16'sd10, 16'sd20, 10);
      issue(mcsc_pkg::ReqButton, ActRightUp, 3'd0, 16'sd10, 16'sd20, 10);
    end
    // mid release outside the click window
    issue(mcsc_pkg::ReqButton, mcsc_pkg::ActMidDown, 3'd4, 16'sd1, 16'sd2, 10);
    issue(mcsc_pkg::ReqButton, ActMidUp, 3'd0, 16'sd1, 16'sd2, 500);
    // left held: first repeat just past the delay, next just past the period
    issue(mcsc_pkg::ReqButton, ActLeftDown, 3'd0, 16'sd7, 16'sd8, 10);
    issue(mcsc_pkg::ReqTick, ActLeftDown, 3'd1, 16'sd0, 16'sd0, 400);
    issue(mcsc_pkg::ReqTick, ActLeftDown, 3'd1, 16'sd0, 16'sd0, 1);
    issue(mcsc_pkg::ReqTick, ActLeftDown, 3'd1, 16'sd0, 16'sd0, 100);
    issue(mcsc_pkg::ReqTick, ActLeftDown, 3'd1, 16'sd0, 16'sd0, 1);
    issue(mcsc_pkg::ReqButton, mcsc_pkg::ActLeftUp, 3'd0, 16'sd7, 16'sd8, 1);
    // reserved request types act as ticks
    for (int r = mcsc_pkg::ReqShift + 1; r <= ReqLast; r++)
      issue(r[2:0], ActLeftDown, 3'd0, 16'sd5, 16'sd5, 1);
    // run across the timestamp wrap
    stamp_ms = 32'hffff_fff0;
    issue(mcsc_pkg::ReqButton, ActRightDown, 3'd0, 16'sd9, 16'sd9, 0);
    issue(mcsc_pkg::ReqButton, ActRightUp, 3'd0, 16'sd9, 16'sd9, 32);
    issue(mcsc_pkg::ReqButton, ActRightDown, 3'd0, 16'sd9, 16'sd9, 5);
    issue(mcsc_pkg::ReqButton, ActRightUp, 3'd0, 16'sd9, 16'sd9, 5);
  endtask

  initial begin
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= mcsc_pkg::CfgClickWindow;
    cfg_data             <= '0;
    in_req.valid         <= 1'b0;
    in_req.req_type      <= mcsc_pkg::ReqTick;
    in_req.button_action <= ActLeftDown;
    in_req.held_buttons  <= '0;
    in_req.pos_x         <= '0;
    in_req.pos_y         <= '0;
    in_req.time_ms       <= '0;
    win_ms    = mcsc_pkg::ClickWindowRst;
    delay_ms  = mcsc_pkg::RepeatDelayRst;
    period_ms = mcsc_pkg::RepeatPeriodRst;
    stamp_ms  = '0;
    n_sent    = 0;
    steady    = 1'b0;
    hold_out  = 1'b0;
    hold_cnt  = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed();
    run_scenes(250);

    write_cfg(16'd1, 16'd1, 16'd1);
    run_scenes(500);

    write_cfg(16'hffff, 16'hffff, 16'hffff);
    run_scenes(620);
    drain();
    run_scenes(750);

    write_cfg(16'($urandom_range(50, 1000)), 16'($urandom_range(50, 1000)),
              16'($urandom_range(1, 300)));
    // results held back while requests keep coming
    hold_out = 1'b1;
    run_scenes(1000);

    write_cfg(16'd0, 16'd0, 16'd0);
    run_scenes(1250);

    write_cfg(16'($urandom), 16'($urandom), 16'($urandom));
    steady = 1'b1;
    run_scenes(1500);
    steady = 1'b0;

    write_cfg(16'($urandom_range(1, 600)), 16'($urandom_range(1, 600)),
              16'($urandom_range(1, 200)));
    run_scenes(1750);

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("mouse_click_sequence_classifier_top: match");
    end else begin
      $display("mouse_click_sequence_classifier_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
